@@ hdl/lwls_pkg.sv @@
// Shared constants, codes and widths for the wavelength-lock stepper.
package lwls_pkg;

  localparam int HeaterW  = 20;
  localparam int PiezoW   = 18;
  localparam int StepW    = 16;
  localparam int LevelW   = 16;
  localparam int BandW    = 10;
  localparam int CmdW     = 3;
  localparam int ModeW    = 3;
  localparam int PosW     = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam int MulAW = 2 * LevelW;
  localparam int MulBW = LevelW;
  localparam int MulPW = MulAW + MulBW;

  localparam logic [HeaterW-1:0]       HEATER_MAX = 20'd1000000;
  localparam logic signed [PiezoW-1:0] PIEZO_MAX  = 18'sd100000;
  localparam logic signed [PiezoW-1:0] PIEZO_MIN  = -18'sd100000;

  localparam logic [CmdW-1:0] CMD_NONE = 3'd0;
  localparam logic [CmdW-1:0] CMD_STOP = 3'd1;
  localparam logic [CmdW-1:0] CMD_FWD  = 3'd2;
  localparam logic [CmdW-1:0] CMD_BACK = 3'd3;
  localparam logic [CmdW-1:0] CMD_LOCK = 3'd4;
  localparam logic [CmdW-1:0] CMD_END  = 3'd5;

  localparam logic [ModeW-1:0] MODE_STOP = 3'd0;
  localparam logic [ModeW-1:0] MODE_FWD  = 3'd1;
  localparam logic [ModeW-1:0] MODE_BACK = 3'd2;
  localparam logic [ModeW-1:0] MODE_LOCK = 3'd3;
  localparam logic [ModeW-1:0] MODE_END  = 3'd4;

  localparam logic [PosW-1:0] POS_INSIDE = 2'd0;
  localparam logic [PosW-1:0] POS_ABOVE  = 2'd1;
  localparam logic [PosW-1:0] POS_BELOW  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_HEATER_START  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PIEZO_START   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COARSE_STEP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FINE_STEP     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PIEZO_STEP    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LOW_LIMIT     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HIGH_LIMIT    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_LOCK_BAND     = 3'd7;

  localparam logic [HeaterW-1:0]       RST_HEATER_START = 20'd621400;
  localparam logic signed [PiezoW-1:0] RST_PIEZO_START  = 18'sd20000;
  localparam logic [StepW-1:0]         RST_COARSE_STEP  = 16'd699;
  localparam logic [StepW-1:0]         RST_FINE_STEP    = 16'd44;
  localparam logic [StepW-1:0]         RST_PIEZO_STEP   = 16'd0;
  localparam logic [HeaterW-1:0]       RST_LOW_LIMIT    = 20'd613000;
  localparam logic [HeaterW-1:0]       RST_HIGH_LIMIT   = 20'd633000;
  localparam logic [BandW-1:0]         RST_LOCK_BAND    = 10'd307;

endpackage

@@ hdl/lwls_if.sv @@
// Request and result channel interfaces of the wavelength-lock stepper.
interface lwls_in_if import lwls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [LevelW-1:0] plus_level;
  logic [LevelW-1:0] minus_level;

  modport source (output valid, command, plus_level, minus_level, input ready);
  modport sink (input valid, command, plus_level, minus_level, output ready);
endinterface

interface lwls_out_if import lwls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [HeaterW-1:0]       heater_setpoint;
  logic signed [PiezoW-1:0] piezo_setpoint;
  logic [ModeW-1:0]         active_mode;
  logic [PosW-1:0]          band_position;

  modport source (output valid, heater_setpoint, piezo_setpoint, active_mode,
                  band_position, input ready);
  modport sink (input valid, heater_setpoint, piezo_setpoint, active_mode,
                band_position, output ready);
endinterface

@@ hdl/laser_wavelength_lock_stepper_core.sv @@
// Top level of the wavelength-lock stepper: sequencer, setpoint state and lock test.
//
//   channel   dir   handshake         payload
//   in_ch     in    valid / ready     command, plus_level, minus_level
//   out_ch    out   valid / ready     heater_setpoint, piezo_setpoint, active_mode,
//                                     band_position
//   cfg       in    cfg_we            cfg_index, cfg_data
//
// Outside lock a request passes through the mode and update steps; in lock the
// lock test runs four products through the one shared multiplier, then a compare.
// Reset (rst, synchronous) restores register defaults and clears mode and history.
// The result waits in an output register; if it is still not taken when the next
// result is ready, the sequencer holds in its update step.
module laser_wavelength_lock_stepper_core import lwls_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  lwls_in_if.sink             in_ch,
  lwls_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MODE, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_CMP, S_UPD
  } state_t;

  state_t state;

  logic [HeaterW-1:0]       heater_start;
  logic signed [PiezoW-1:0] piezo_start;
  logic [StepW-1:0]         coarse_step;
  logic [StepW-1:0]         fine_step;
  logic [StepW-1:0]         piezo_step;
  logic [HeaterW-1:0]       low_limit;
  logic [HeaterW-1:0]       high_limit;
  logic [BandW-1:0]         lock_band;

  logic [HeaterW-1:0]       heater;
  logic signed [PiezoW-1:0] piezo;
  logic                     started;
  logic [ModeW-1:0]         mode;
  logic                     lock_armed;
  logic [LevelW-1:0]        last_plus, last_minus, ref_plus, ref_minus;

  logic [CmdW-1:0]          cmd_r;
  logic [LevelW-1:0]        plus_r, minus_r;
  logic [PosW-1:0]          pos;
  logic [MulAW-1:0]         lhs, rhs;
  logic [MulAW+BandW-1:0]   lhs_b;

  logic                     out_valid;
  logic [HeaterW-1:0]       out_heater;
  logic signed [PiezoW-1:0] out_piezo;
  logic [ModeW-1:0]         out_mode;
  logic [PosW-1:0]          out_pos;

  logic [MulAW-1:0]         mul_a;
  logic [MulBW-1:0]         mul_b;
  logic [MulPW-1:0]         prod;

  logic [HeaterW-1:0]       hv;
  logic signed [PiezoW-1:0] pv;
  logic [ModeW-1:0]         mode_next;
  logic [LevelW-1:0]        mm, rm;
  logic [MulAW+BandW-1:0]   rhs_sh, lhs_sh, rhs_b;
  logic signed [StepW:0]    dh, dp;
  logic signed [HeaterW+1:0] h_sum;
  logic signed [PiezoW+1:0]  p_sum;
  logic [HeaterW-1:0]       heater_next;
  logic signed [PiezoW-1:0] piezo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      heater_start <= RST_HEATER_START;
      piezo_start  <= RST_PIEZO_START;
      coarse_step  <= RST_COARSE_STEP;
      fine_step    <= RST_FINE_STEP;
      piezo_step   <= RST_PIEZO_STEP;
      low_limit    <= RST_LOW_LIMIT;
      high_limit   <= RST_HIGH_LIMIT;
      lock_band    <= RST_LOCK_BAND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEATER_START: heater_start <= cfg_data[HeaterW-1:0];
        REG_PIEZO_START:  piezo_start  <= $signed(cfg_data[PiezoW-1:0]);
        REG_COARSE_STEP:  coarse_step  <= cfg_data[StepW-1:0];
        REG_FINE_STEP:    fine_step    <= cfg_data[StepW-1:0];
        REG_PIEZO_STEP:   piezo_step   <= cfg_data[StepW-1:0];
        REG_LOW_LIMIT:    low_limit    <= cfg_data[HeaterW-1:0];
        REG_HIGH_LIMIT:   high_limit   <= cfg_data[HeaterW-1:0];
        REG_LOCK_BAND:    lock_band    <= cfg_data[BandW-1:0];
        default: ;
      endcase
    end
  end

  // start values are loaded on the first request
  always_comb begin
    if (started) begin
      hv = heater;
      pv = piezo;
    end else begin
      hv = (heater_start > HEATER_MAX) ? HEATER_MAX : heater_start;
      if (piezo_start > PIEZO_MAX) begin
        pv = PIEZO_MAX;
      end else if (piezo_start < PIEZO_MIN) begin
        pv = PIEZO_MIN;
      end else begin
        pv = piezo_start;
      end
    end
  end

  always_comb begin
    mode_next = mode;
    if (mode != MODE_END) begin
      if (hv > high_limit) begin
        mode_next = MODE_BACK;
      end
      if (hv < low_limit) begin
        mode_next = MODE_FWD;
      end
      case (cmd_r)
        CMD_STOP: mode_next = MODE_STOP;
        CMD_FWD:  mode_next = MODE_FWD;
        CMD_BACK: mode_next = MODE_BACK;
        CMD_LOCK: mode_next = MODE_LOCK;
        CMD_END:  mode_next = MODE_END;
        default: ;
      endcase
    end
  end

  assign mm = (minus_r == '0) ? LevelW'(1) : minus_r;
  assign rm = (ref_minus == '0) ? LevelW'(1) : ref_minus;

  always_comb begin
    unique case (state)
      S_MUL1: begin
        mul_a = MulAW'(plus_r);
        mul_b = rm;
      end
      S_MUL2: begin
        mul_a = MulAW'(ref_plus);
        mul_b = mm;
      end
      S_MUL3: begin
        mul_a = lhs;
        mul_b = MulBW'(lock_band);
      end
      S_MUL4: begin
        mul_a = rhs;
        mul_b = MulBW'(lock_band);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lwls_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign rhs_sh = {{(BandW-8){1'b0}}, rhs, 8'd0};
  assign lhs_sh = {{(BandW-8){1'b0}}, lhs, 8'd0};
  assign rhs_b  = prod[MulAW+BandW-1:0];

  always_comb begin
    dh = '0;
    dp = '0;
    unique case (mode)
      MODE_FWD: begin
        dh = $signed({1'b0, coarse_step});
        dp = -$signed({1'b0, piezo_step});
      end
      MODE_BACK: begin
        dh = -$signed({1'b0, coarse_step});
        dp = $signed({1'b0, piezo_step});
      end
      MODE_LOCK: begin
        if (pos == POS_BELOW) begin
          dh = $signed({1'b0, fine_step});
        end else if (pos == POS_ABOVE) begin
          dh = -$signed({1'b0, fine_step});
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    h_sum = $signed({2'b00, heater}) + {{(HeaterW+1-StepW){dh[StepW]}}, dh};
    p_sum = {{2{piezo[PiezoW-1]}}, piezo} + {{(PiezoW+1-StepW){dp[StepW]}}, dp};
    if (h_sum < 0) begin
      heater_next = '0;
    end else if (h_sum > $signed({2'b00, HEATER_MAX})) begin
      heater_next = HEATER_MAX;
    end else begin
      heater_next = h_sum[HeaterW-1:0];
    end
    if (p_sum > $signed({{2{PIEZO_MAX[PiezoW-1]}}, PIEZO_MAX})) begin
      piezo_next = PIEZO_MAX;
    end else if (p_sum < $signed({{2{PIEZO_MIN[PiezoW-1]}}, PIEZO_MIN})) begin
      piezo_next = PIEZO_MIN;
    end else begin
      piezo_next = p_sum[PiezoW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      started    <= 1'b0;
      mode       <= MODE_STOP;
      lock_armed <= 1'b0;
      last_plus  <= '0;
      last_minus <= '0;
      ref_plus   <= '0;
      ref_minus  <= '0;
      heater     <= '0;
      piezo      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_UPD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= in_ch.command;
            plus_r  <= in_ch.plus_level;
            minus_r <= in_ch.minus_level;
            state   <= S_MODE;
          end
        end
        S_MODE: begin
          started    <= 1'b1;
          heater     <= hv;
          piezo      <= pv;
          mode       <= mode_next;
          pos        <= POS_INSIDE;
          lock_armed <= (mode_next == MODE_LOCK);
          if (mode_next == MODE_LOCK) begin
            if (!lock_armed) begin
              ref_plus  <= last_plus;
              ref_minus <= last_minus;
            end
            state <= S_MUL1;
          end else begin
            state <= S_UPD;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: begin
          lhs   <= prod[MulAW-1:0];
          state <= S_MUL3;
        end
        S_MUL3: begin
          rhs   <= prod[MulAW-1:0];
          state <= S_MUL4;
        end
        S_MUL4: begin
          lhs_b <= prod[MulAW+BandW-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (lhs_b < rhs_sh) begin
            pos <= POS_BELOW;
          end else if (lhs_sh > rhs_b) begin
            pos <= POS_ABOVE;
          end
          state <= S_UPD;
        end
        S_UPD: begin
          if (!out_valid || out_ch.ready) begin
            heater     <= heater_next;
            piezo      <= piezo_next;
            last_plus  <= plus_r;
            last_minus <= minus_r;
            out_valid  <= 1'b1;
            out_heater <= heater_next;
            out_piezo  <= piezo_next;
            out_mode   <= mode;
            out_pos    <= pos;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = (state == S_IDLE) && !rst;
  assign out_ch.valid           = out_valid;
  assign out_ch.heater_setpoint = out_heater;
  assign out_ch.piezo_setpoint  = out_piezo;
  assign out_ch.active_mode     = out_mode;
  assign out_ch.band_position   = out_pos;

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_UPD)
    else $error("result raised outside update step");

  a_heater_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_heater <= HEATER_MAX)
    else $error("heater setpoint out of range");

  a_band_only_in_lock: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pos != POS_INSIDE) |-> out_mode == MODE_LOCK)
    else $error("band position set outside lock");

  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_END |=> mode == MODE_END)
    else $error("ended mode left before reset");

endmodule

@@ hdl/lwls_mul.sv @@
// Shared unsigned multiplier with registered product.
module lwls_mul import lwls_pkg::*; (
  input  logic             clk,
  input  logic [MulAW-1:0] a,
  input  logic [MulBW-1:0] b,
  output logic [MulPW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ test/laser_wavelength_lock_stepper_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the wavelength-lock stepper: directed modes, lock band and random traffic.
module laser_wavelength_lock_stepper_core_test;
  import lwls_pkg::*;

  localparam logic [CmdW-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE7 = 3'd7;
  localparam logic [CfgDataW-1:0] DATA_FULL = '1;
  localparam logic [CfgDataW-1:0] PIEZO_MOST_NEG = CfgDataW'({1'b1, {(PiezoW-1){1'b0}}});
  localparam int CYCLE_LIMIT = 250000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_STRETCH = 300;
  localparam int RANDOM_REQUESTS = 900;

  typedef struct packed {
    logic [HeaterW-1:0]       heater;
    logic signed [PiezoW-1:0] piezo;
    logic [ModeW-1:0]         mode;
    logic [PosW-1:0]          pos;
  } setpoint_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  lwls_in_if  in_ch ();
  lwls_out_if out_ch ();

  laser_wavelength_lock_stepper_core uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor registers and state
  logic [HeaterW-1:0]       cfg_heater_start = RST_HEATER_START;
  logic signed [PiezoW-1:0] cfg_piezo_start  = RST_PIEZO_START;
  logic [StepW-1:0]         cfg_coarse_step  = RST_COARSE_STEP;
  logic [StepW-1:0]         cfg_fine_step    = RST_FINE_STEP;
  logic [StepW-1:0]         cfg_piezo_step   = RST_PIEZO_STEP;
  logic [HeaterW-1:0]       cfg_low_limit    = RST_LOW_LIMIT;
  logic [HeaterW-1:0]       cfg_high_limit   = RST_HIGH_LIMIT;
  logic [BandW-1:0]         cfg_lock_band    = RST_LOCK_BAND;

  int                heater_now = 0;
  int                piezo_now = 0;
  bit                loaded = 1'b0;
  bit                lock_held = 1'b0;
  logic [ModeW-1:0]  mode_now = MODE_STOP;
  logic [LevelW-1:0] prev_plus = '0;
  logic [LevelW-1:0] prev_minus = '0;
  logic [LevelW-1:0] anchor_plus = '0;
  logic [LevelW-1:0] anchor_minus = '0;

  setpoint_t pending_setpoints[$];

  int  sent_count = 0;
  int  checked_count = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  rx_wait = 0;
  int  taken_count = 0;
  int  taken_seen = 0;
  int  hold_cycles = 0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  inside_hits = 0;
  int  above_hits = 0;
  int  below_hits = 0;
  bit  quiet_sender = 1'b0;
  bit  quiet_receiver = 1'b0;

  function automatic int clamp_int(longint v, longint lo, longint hi);
    if (v < lo) return int'(lo);
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  function automatic setpoint_t predict_setpoints(logic [CmdW-1:0] cmd, logic [LevelW-1:0] p,
                                                  logic [LevelW-1:0] m);
    longint          dh;
    longint          dp;
    longint unsigned m_eff;
    longint unsigned r_eff;
    longint unsigned lhs;
    longint unsigned rhs;
    setpoint_t       res;
    dh = 0;
    dp = 0;
    res.pos = POS_INSIDE;
    if (!loaded) begin
      heater_now = clamp_int(longint'(cfg_heater_start), 0, longint'(HEATER_MAX));
      piezo_now = clamp_int(longint'(cfg_piezo_start), longint'(PIEZO_MIN),
                            longint'(PIEZO_MAX));
      loaded = 1'b1;
    end
    if (mode_now != MODE_END) begin
      if (heater_now > int'(cfg_high_limit)) mode_now = MODE_BACK;
      if (heater_now < int'(cfg_low_limit)) mode_now = MODE_FWD;
      case (cmd)
        CMD_STOP: mode_now = MODE_STOP;
        CMD_FWD:  mode_now = MODE_FWD;
        CMD_BACK: mode_now = MODE_BACK;
        CMD_LOCK: mode_now = MODE_LOCK;
        CMD_END:  mode_now = MODE_END;
        default: ;
      endcase
    end
    case (mode_now)
      MODE_FWD: begin
        dh = longint'(cfg_coarse_step);
        dp = -longint'(cfg_piezo_step);
      end
      MODE_BACK: begin
        dh = -longint'(cfg_coarse_step);
        dp = longint'(cfg_piezo_step);
      end
      MODE_LOCK: begin
        if (!lock_held) begin
          anchor_plus = prev_plus;
          anchor_minus = prev_minus;
        end
        m_eff = (m == '0) ? 1 : m;
        r_eff = (anchor_minus == '0) ? 1 : anchor_minus;
        lhs = r_eff * p;
        rhs = m_eff * anchor_plus;
        if (lhs * cfg_lock_band < rhs * 256) begin
          res.pos = POS_BELOW;
          dh = longint'(cfg_fine_step);
        end else if (lhs * 256 > rhs * cfg_lock_band) begin
          res.pos = POS_ABOVE;
          dh = -longint'(cfg_fine_step);
        end
      end
      default: ;
    endcase
    lock_held = (mode_now == MODE_LOCK);
    heater_now = clamp_int(heater_now + dh, 0, longint'(HEATER_MAX));
    piezo_now = clamp_int(piezo_now + dp, longint'(PIEZO_MIN), longint'(PIEZO_MAX));
    prev_plus = p;
    prev_minus = m;
    res.heater = heater_now[HeaterW-1:0];
    res.piezo = piezo_now[PiezoW-1:0];
    res.mode = mode_now;
    return res;
  endfunction

  function automatic void mirror_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_HEATER_START: cfg_heater_start = data[HeaterW-1:0];
      REG_PIEZO_START:  cfg_piezo_start = data[PiezoW-1:0];
      REG_COARSE_STEP:  cfg_coarse_step = data[StepW-1:0];
      REG_FINE_STEP:    cfg_fine_step = data[StepW-1:0];
      REG_PIEZO_STEP:   cfg_piezo_step = data[StepW-1:0];
      REG_LOW_LIMIT:    cfg_low_limit = data[HeaterW-1:0];
      REG_HIGH_LIMIT:   cfg_high_limit = data[HeaterW-1:0];
      REG_LOCK_BAND:    cfg_lock_band = data[BandW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [LevelW-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return LevelW'($urandom_range(1, 255));
      default: return LevelW'($urandom);
    endcase
  endfunction

  // plus level that puts p/m near the anchor ratio rp/rm
  function automatic logic [LevelW-1:0] near_level(logic [LevelW-1:0] rp, logic [LevelW-1:0] rm,
                                                   logic [LevelW-1:0] m);
    longint unsigned num;
    longint unsigned den;
    num = rp;
    num = num * m * $urandom_range(200, 340);
    den = (rm == '0) ? 256 : rm * 256;
    num = num / den;
    return (num > 65535) ? '1 : num[LevelW-1:0];
  endfunction

  function automatic logic [CfgDataW-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CfgDataW'({StepW{1'b1}});
      2: return CfgDataW'($urandom_range(1, 100));
      3: return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(100, 5000));
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    mirror_reg(idx, data);
  endtask

  task automatic send_request(logic [CmdW-1:0] cmd, logic [LevelW-1:0] p,
                              logic [LevelW-1:0] m);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.plus_level <= p;
    in_ch.minus_level <= m;
    do @(posedge clk); while (!in_ch.ready);
    pending_setpoints.push_back(predict_setpoints(cmd, p, m));
    sent_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    setpoint_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_setpoints.size() == 0) begin
        $error("result with no pending request");
        mismatches++;
      end else begin
        want = pending_setpoints.pop_front();
        checked_count++;
        if (out_ch.heater_setpoint !== want.heater) begin
          $error("heater_setpoint: expected %0d, got %0d", want.heater,
                 out_ch.heater_setpoint);
          mismatches++;
        end
        if (out_ch.piezo_setpoint !== want.piezo) begin
          $error("piezo_setpoint: expected %0d, got %0d", $signed(want.piezo),
                 $signed(out_ch.piezo_setpoint));
          mismatches++;
        end
        if (out_ch.active_mode !== want.mode) begin
          $error("active_mode: expected %0d, got %0d", want.mode, out_ch.active_mode);
          mismatches++;
        end
        if (out_ch.band_position !== want.pos) begin
          $error("band_position: expected %0d, got %0d", want.pos, out_ch.band_position);
          mismatches++;
        end
        if (want.mode == MODE_LOCK) begin
          case (want.pos)
            POS_ABOVE: above_hits++;
            POS_BELOW: below_hits++;
            default: inside_hits++;
          endcase
        end
      end
      taken_count++;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (taken_seen != taken_count) begin
      taken_seen = taken_count;
      rx_wait = quiet_receiver ? 0 : $urandom_range(0, 15);
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
    end else if (rx_wait != 0) begin
      out_ch.ready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_cycles <= HOLD_STRETCH;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // start values out of range are clamped; very first lock takes a zero reference
  task automatic test_start_clamp();
    write_reg(REG_HEATER_START, DATA_FULL);
    write_reg(REG_PIEZO_START, PIEZO_MOST_NEG);
    send_request(CMD_LOCK, 16'd1234, '0);
  endtask

  task automatic test_reset_defaults();
    send_request(CMD_FWD, rand_level(), rand_level());
    send_request(CMD_STOP, rand_level(), rand_level());
    send_request(CMD_BACK, rand_level(), rand_level());
  endtask

  task automatic test_limit_forcing();
    wait_idle();
    write_reg(REG_LOW_LIMIT, CfgDataW'(HEATER_MAX));
    write_reg(REG_HIGH_LIMIT, '0);
    send_request(CMD_NONE, rand_level(), rand_level());
    send_request(CMD_BACK, rand_level(), rand_level());
    wait_idle();
    write_reg(REG_LOW_LIMIT, '0);
    send_request(CMD_NONE, rand_level(), rand_level());
  endtask

  task automatic test_saturation();
    wait_idle();
    write_reg(REG_COARSE_STEP, CfgDataW'({StepW{1'b1}}));
    write_reg(REG_PIEZO_STEP, CfgDataW'({StepW{1'b1}}));
    write_reg(REG_HIGH_LIMIT, DATA_FULL);
    send_request(CMD_FWD, rand_level(), rand_level());
    send_request(CMD_FWD, rand_level(), rand_level());
  endtask

  task automatic test_spare_commands();
    send_request(CMD_SPARE6, rand_level(), rand_level());
    send_request(CMD_SPARE7, rand_level(), rand_level());
  endtask

  task automatic test_lock_band();
    // zero minus reference taken as 1
    send_request(CMD_STOP, 16'd1000, '0);
    send_request(CMD_LOCK, 16'd1000, 16'd1);
    send_request(CMD_NONE, 16'd2000, 16'd1);
    send_request(CMD_NONE, 16'd500, '0);
    send_request(CMD_STOP, 16'd300, 16'd100);
    send_request(CMD_LOCK, 16'd330, 16'd100);
    send_request(CMD_NONE, '0, '0);
    wait_idle();
    write_reg(REG_LOCK_BAND, CfgDataW'(10'd128));
    send_request(CMD_NONE, 16'd300, 16'd100);
    wait_idle();
    write_reg(REG_LOCK_BAND, CfgDataW'(10'd256));
    send_request(CMD_NONE, 16'd300, 16'd100);
    wait_idle();
    write_reg(REG_LOCK_BAND, CfgDataW'({BandW{1'b1}}));
    send_request(CMD_NONE, 16'd300, 16'd100);
    send_request(CMD_NONE, '1, 16'd1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    quiet_sender = 1'b1;
    @(posedge clk);
    hold_requests++;
    repeat (24) send_request(CmdW'($urandom_range(CMD_NONE, CMD_LOCK)), rand_level(),
                             rand_level());
    quiet_sender = 1'b0;
    wait_idle();
  endtask

  task automatic randomize_config();
    int lo;
    int hi;
    write_reg(REG_HEATER_START, CfgDataW'($urandom));
    write_reg(REG_PIEZO_START, CfgDataW'($urandom));
    write_reg(REG_COARSE_STEP, pick_step());
    write_reg(REG_FINE_STEP, pick_step());
    write_reg(REG_PIEZO_STEP, pick_step());
    case ($urandom_range(0, 5))
      0: begin
        lo = 0;
        hi = int'(DATA_FULL);
      end
      1: begin
        lo = $urandom_range(0, DATA_FULL);
        hi = $urandom_range(0, DATA_FULL);
      end
      2: begin
        lo = int'(DATA_FULL);
        hi = 0;
      end
      default: begin
        lo = heater_now - int'($urandom_range(0, 60000));
        hi = heater_now + int'($urandom_range(0, 60000));
        if (lo < 0) lo = 0;
        if (hi > int'(DATA_FULL)) hi = int'(DATA_FULL);
      end
    endcase
    write_reg(REG_LOW_LIMIT, CfgDataW'(lo));
    write_reg(REG_HIGH_LIMIT, CfgDataW'(hi));
    case ($urandom_range(0, 5))
      0: write_reg(REG_LOCK_BAND, CfgDataW'(10'd256));
      1: write_reg(REG_LOCK_BAND, CfgDataW'({BandW{1'b1}}));
      2: write_reg(REG_LOCK_BAND, CfgDataW'($urandom_range(0, 255)));
      default: write_reg(REG_LOCK_BAND, CfgDataW'($urandom_range(256, 1023)));
    endcase
  endtask

  task automatic run_burst();
    int                kind;
    int                n;
    logic [LevelW-1:0] ref_p;
    logic [LevelW-1:0] ref_m;
    logic [LevelW-1:0] m;
    logic [CmdW-1:0]   cmd;
    kind = $urandom_range(0, 9);
    n = $urandom_range(2, 16);
    if (kind < 5) begin
      ref_p = rand_level();
      ref_m = rand_level();
      send_request(CmdW'($urandom_range(CMD_NONE, CMD_BACK)), ref_p, ref_m);
      m = rand_level();
      send_request(CMD_LOCK, near_level(ref_p, ref_m, m), m);
      repeat (n) begin
        m = rand_level();
        cmd = ($urandom_range(0, 7) == 0) ? CMD_LOCK : CMD_NONE;
        send_request(cmd, near_level(ref_p, ref_m, m), m);
      end
    end else if (kind < 8) begin
      send_request($urandom_range(0, 1) ? CMD_FWD : CMD_BACK, rand_level(), rand_level());
      repeat (n) send_request(CMD_NONE, rand_level(), rand_level());
      if ($urandom_range(0, 1)) send_request(CMD_STOP, rand_level(), rand_level());
    end else begin
      repeat (n) begin
        cmd = CmdW'($urandom_range(CMD_NONE, CMD_SPARE6));
        if (cmd == CMD_END) cmd = CMD_SPARE7;
        send_request(cmd, rand_level(), rand_level());
      end
    end
  endtask

  task automatic test_random_traffic();
    int target;
    int phase_end;
    wait_idle();
    target = sent_count + RANDOM_REQUESTS;
    while (sent_count < target) begin
      randomize_config();
      quiet_sender = ($urandom_range(0, 3) == 0);
      quiet_receiver = ($urandom_range(0, 3) == 0);
      phase_end = sent_count + $urandom_range(40, 120);
      while (sent_count < phase_end) run_burst();
      wait_idle();
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // ended is sticky: commands and limit forcing are ignored afterwards
  task automatic test_end_freeze();
    wait_idle();
    write_reg(REG_LOW_LIMIT, DATA_FULL);
    write_reg(REG_HIGH_LIMIT, '0);
    send_request(CMD_END, rand_level(), rand_level());
    send_request(CMD_FWD, rand_level(), rand_level());
    send_request(CMD_LOCK, rand_level(), rand_level());
    send_request(CMD_NONE, rand_level(), rand_level());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_NONE;
    in_ch.plus_level = '0;
    in_ch.minus_level = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_start_clamp();
    test_reset_defaults();
    test_limit_forcing();
    test_saturation();
    test_spare_commands();
    test_lock_band();
    test_backpressure();
    test_random_traffic();
    test_end_freeze();
    wait_idle();
    $display("Summary: %0d requests sent, %0d results checked, %0d mismatches",
             sent_count, checked_count, mismatches);
    $display("Lock results inside/above/below: %0d/%0d/%0d",
             inside_hits, above_hits, below_hits);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lwls_pkg.sv
hdl/lwls_if.sv
hdl/lwls_mul.sv
hdl/laser_wavelength_lock_stepper_core.sv
test/laser_wavelength_lock_stepper_core_test.sv
